// File: sv/assert_macros.svh
// assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: sv/dteq_pkg.sv
// ----------------------------------------------------------------------------
// dteq_pkg
// Shared types and codes of the delta timer event queue.
// ----------------------------------------------------------------------------
package dteq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_TIME_BITS   = 48;

    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    localparam logic [2:0] KIND_FIRED    = 3'd0;
    localparam logic [2:0] KIND_ARM      = 3'd1;
    localparam logic [2:0] KIND_EMPTY    = 3'd2;
    localparam logic [2:0] KIND_FULL     = 3'd3;
    localparam logic [2:0] KIND_NOTFOUND = 3'd4;
    localparam logic [2:0] KIND_DUP      = 3'd5;

    localparam logic [1:0] CFG_TIMER_MAX = 2'd0;
    localparam logic [1:0] CFG_OWN_CORE  = 2'd1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [47:0] elapsed_nanos;
        logic [5:0]  event_id;
        logic [7:0]  target_core;
        logic        any_core;
        logic [47:0] delay_nanos;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [5:0]  fired_id;
        logic [7:0]  fired_core;
        logic        is_remote;
        logic [47:0] arm_nanos;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_emit;

endpackage

// File: sv/delta_timer_event_queue_core.sv
// ----------------------------------------------------------------------------
// delta_timer_event_queue_core
// Sorted delta list of timer events with tick, insert and remove requests.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_stall    | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall  | o_out_data (t_out_item)
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One request at a time. Each memory visit is a read state, then a state
// that uses the data and writes back; one visit per entry drained, searched
// or shifted. A tick shifts the whole remaining list once per popped entry.
// Reset clears the entry count, sets the timer max to all ones and the owner
// core to zero; entry memory needs no clearing. A stalled output beat holds
// the sequencer only when it has a new beat.
// ----------------------------------------------------------------------------
module delta_timer_event_queue_core
    import dteq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int TIME_BITS   = DEF_TIME_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);

    logic [47:0] r_timer_max;
    logic [7:0]  r_own_core;
    logic        r_out_valid;
    t_out_item   r_out;
    t_emit       emit;
    logic        emit_ok;
    logic        busy;
    logic        start;

    assign start   = i_in_valid && !busy;
    // output slot frees when empty or when the waiting beat leaves now
    assign emit_ok = !r_out_valid || !i_out_stall;

    dteq_seq #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_item      (i_in_data),
        .i_timer_max (r_timer_max),
        .i_own_core  (r_own_core),
        .i_emit_ok   (emit_ok),
        .o_emit      (emit),
        .o_busy      (busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer_max <= '1;
            r_own_core  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_TIMER_MAX: r_timer_max <= i_cfg_data;
                    CFG_OWN_CORE:  r_own_core  <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (emit.valid && emit_ok) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (emit.valid && emit_ok) begin
            r_out <= emit.item;
        end
    end

    assign o_in_stall  = busy;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: sv/dteq_mem.sv
// ----------------------------------------------------------------------------
// dteq_mem
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dteq_mem #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 62
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/dteq_seq.sv
// ----------------------------------------------------------------------------
// dteq_seq
// Request sequencer: drains, searches, shifts and reports over the entry memory.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dteq_seq
    import dteq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int TIME_BITS   = DEF_TIME_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_in_item    i_item,
    input  logic [47:0] i_timer_max,
    input  logic [7:0]  i_own_core,
    input  logic        i_emit_ok,
    output t_emit       o_emit,
    output logic        o_busy
);

    localparam int TB     = TIME_BITS;
    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int DATA_W = TB + 14;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE, S_DR_RD, S_DR_EX, S_POST, S_TK_RD, S_TK_EX, S_FD_RD, S_FD_EX,
        S_PS_RD, S_PS_EX, S_IS_RD, S_IS_EX, S_IS_WR, S_SH_RD, S_SH_EX,
        S_ST_RD, S_ST_EX
    } t_state;

    t_state           r_state, n_state;
    logic [1:0]       r_req, n_req;
    logic [5:0]       r_id, n_id;
    logic [7:0]       r_core, n_core;
    logic [TB-1:0]    r_t, n_t;
    logic [TB-1:0]    r_dly, n_dly;
    logic [TB-1:0]    r_carry, n_carry;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0] r_count, n_count;
    logic [2:0]       r_kind, n_kind;

    logic              wr_en, rd_en;
    logic [CNT_W-1:0]  wr_addr, rd_addr;
    logic [DATA_W-1:0] wr_data, rd_data;
    logic [TB-1:0]     rd_delta;
    logic [5:0]        rd_id;
    logic [7:0]        rd_core;
    logic [63:0]       ext_elapsed, ext_delay, ext_tmax, ext_arm;
    logic [TB-1:0]     in_elapsed, in_delay, tmax, arm_tb;
    logic [CNT_W-1:0]  i_inc;

    assign rd_delta = rd_data[DATA_W-1 -: TB];
    assign rd_id    = rd_data[13:8];
    assign rd_core  = rd_data[7:0];

    // field widths to internal time width (mask or zero extend)
    assign ext_elapsed = {16'b0, i_item.elapsed_nanos};
    assign ext_delay   = {16'b0, i_item.delay_nanos};
    assign ext_tmax    = {16'b0, i_timer_max};
    assign in_elapsed  = ext_elapsed[TB-1:0];
    assign in_delay    = ext_delay[TB-1:0];
    assign tmax        = ext_tmax[TB-1:0];
    assign arm_tb      = (rd_delta < tmax) ? rd_delta : tmax;
    assign ext_arm     = 64'(arm_tb);
    assign i_inc       = CNT_W'(r_i + 1'b1);

    dteq_mem #(
        .DEPTH  (QUEUE_DEPTH),
        .DATA_W (DATA_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr[IDX_W-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state = r_state;
        n_req   = r_req;
        n_id    = r_id;
        n_core  = r_core;
        n_t     = r_t;
        n_dly   = r_dly;
        n_carry = r_carry;
        n_i     = r_i;
        n_pos   = r_pos;
        n_count = r_count;
        n_kind  = r_kind;
        wr_en   = 1'b0;
        wr_addr = r_i;
        wr_data = rd_data;
        rd_en   = 1'b0;
        rd_addr = r_i;
        o_emit  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req  = i_item.req_type;
                    n_id   = i_item.event_id;
                    n_core = i_item.any_core ? i_own_core : i_item.target_core;
                    n_t    = in_elapsed;
                    n_dly  = in_delay;
                    n_i    = '0;
                    n_kind = KIND_ARM;
                    n_state = (in_elapsed != '0 && r_count != '0) ? S_DR_RD : S_POST;
                end
            end
            S_DR_RD: begin
                rd_en   = 1'b1;
                n_state = S_DR_EX;
            end
            S_DR_EX: begin
                if (rd_delta != '0 && r_t < rd_delta) begin
                    wr_en   = 1'b1;
                    wr_data = {rd_delta - r_t, rd_id, rd_core};
                    n_state = S_POST;
                end else begin
                    if (rd_delta != '0) begin
                        wr_en   = 1'b1;
                        wr_data = {{TB{1'b0}}, rd_id, rd_core};
                        n_t     = r_t - rd_delta;
                    end
                    n_i     = i_inc;
                    n_state = (i_inc == r_count || n_t == '0) ? S_POST : S_DR_RD;
                end
            end
            S_POST: begin
                n_i = '0;
                unique case (r_req)
                    REQ_TICK:   n_state = S_TK_RD;
                    REQ_INSERT: n_state = S_FD_RD;
                    REQ_REMOVE: n_state = S_FD_RD;
                    default:    n_state = S_ST_RD;
                endcase
            end
            S_TK_RD: begin
                if (r_count == '0) begin
                    n_state = S_ST_RD;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = '0;
                    n_state = S_TK_EX;
                end
            end
            S_TK_EX: begin
                if (rd_delta != '0) begin
                    n_state = S_ST_RD;
                end else begin
                    o_emit.valid           = 1'b1;
                    o_emit.item.kind       = KIND_FIRED;
                    o_emit.item.fired_id   = rd_id;
                    o_emit.item.fired_core = rd_core;
                    o_emit.item.is_remote  = (rd_core != i_own_core);
                    if (i_emit_ok) begin
                        n_pos   = '0;
                        n_i     = '0;
                        n_carry = '0;
                        n_state = S_SH_RD;
                    end
                end
            end
            S_FD_RD: begin
                if (r_i == r_count) begin
                    if (r_req == REQ_REMOVE) begin
                        n_kind  = KIND_NOTFOUND;
                        n_state = S_ST_RD;
                    end else if (r_count == DEPTH_C) begin
                        n_kind  = KIND_FULL;
                        n_state = S_ST_RD;
                    end else begin
                        n_pos   = '0;
                        n_state = S_PS_RD;
                    end
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_FD_EX;
                end
            end
            S_FD_EX: begin
                if (rd_id == r_id) begin
                    if (r_req == REQ_REMOVE) begin
                        n_pos   = r_i;
                        n_carry = rd_delta;
                        n_state = S_SH_RD;
                    end else begin
                        n_kind  = KIND_DUP;
                        n_state = S_ST_RD;
                    end
                end else begin
                    n_i     = i_inc;
                    n_state = S_FD_RD;
                end
            end
            S_PS_RD: begin
                if (r_pos == r_count) begin
                    n_i     = r_count;
                    n_state = S_IS_RD;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_pos;
                    n_state = S_PS_EX;
                end
            end
            S_PS_EX: begin
                if (rd_delta <= r_dly) begin
                    n_dly   = r_dly - rd_delta;
                    n_pos   = CNT_W'(r_pos + 1'b1);
                    n_state = S_PS_RD;
                end else begin
                    // following entry keeps only what is left past the new one
                    wr_en   = 1'b1;
                    wr_addr = r_pos;
                    wr_data = {rd_delta - r_dly, rd_id, rd_core};
                    n_i     = r_count;
                    n_state = S_IS_RD;
                end
            end
            S_IS_RD: begin
                if (r_i == r_pos) begin
                    n_state = S_IS_WR;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = CNT_W'(r_i - 1'b1);
                    n_state = S_IS_EX;
                end
            end
            S_IS_EX: begin
                wr_en   = 1'b1;
                n_i     = CNT_W'(r_i - 1'b1);
                n_state = S_IS_RD;
            end
            S_IS_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_pos;
                wr_data = {r_dly, r_id, r_core};
                n_count = CNT_W'(r_count + 1'b1);
                n_state = S_ST_RD;
            end
            S_SH_RD: begin
                if (i_inc >= r_count) begin
                    n_count = CNT_W'(r_count - 1'b1);
                    n_state = (r_req == REQ_TICK) ? S_TK_RD : S_ST_RD;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = i_inc;
                    n_state = S_SH_EX;
                end
            end
            S_SH_EX: begin
                // removed delta goes to its successor
                wr_en   = 1'b1;
                wr_data = {rd_delta + ((r_i == r_pos) ? r_carry : '0), rd_id, rd_core};
                n_i     = i_inc;
                n_state = S_SH_RD;
            end
            S_ST_RD: begin
                rd_en   = 1'b1;
                rd_addr = '0;
                n_state = S_ST_EX;
            end
            S_ST_EX: begin
                o_emit.valid = 1'b1;
                o_emit.item.last = 1'b1;
                if (r_count != '0) begin
                    o_emit.item.kind      = r_kind;
                    o_emit.item.arm_nanos = ext_arm[47:0];
                end else begin
                    o_emit.item.kind = (r_kind == KIND_ARM) ? KIND_EMPTY : r_kind;
                end
                if (i_emit_ok) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_req   <= n_req;
        r_id    <= n_id;
        r_core  <= n_core;
        r_t     <= n_t;
        r_dly   <= n_dly;
        r_carry <= n_carry;
        r_i     <= n_i;
        r_pos   <= n_pos;
        r_kind  <= n_kind;
    end

    assign o_busy = (r_state != S_IDLE);

    `ASSERT_NEVER(a_count_range, i_clk, i_rst_n, r_count > DEPTH_C, "entry count over depth")
    `ASSERT_CLK(a_start_busy, i_clk, i_rst_n, i_start |=> o_busy, "request not taken up")
    `ASSERT_CLK(a_wr_inside, i_clk, i_rst_n, wr_en |-> (wr_addr <= r_count), "write past list end")

endmodule

// File: sim/dteq_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dteq_scoreboard
// Watches the request, result and config channels of the timer queue, keeps
// its own delta list and checks every result beat against the prediction.
// ----------------------------------------------------------------------------
module dteq_scoreboard
    import dteq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_item    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_item   i_out_data,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_fired_seen,
    output int          o_status_seen
);

    logic [47:0] delay_q [QUEUE_DEPTH];
    logic [5:0]  id_q    [QUEUE_DEPTH];
    logic [7:0]  core_q  [QUEUE_DEPTH];
    int          depth_used;
    logic [47:0] max_arm;
    logic [7:0]  owner;
    t_out_item   expected_beats [$];

    assign o_pending = expected_beats.size();

    function automatic t_out_item mk_beat(logic [2:0] kind, logic [5:0] id,
                                          logic [7:0] core, logic rem,
                                          logic [47:0] arm, logic lst);
        t_out_item b;
        b.kind = kind; b.fired_id = id; b.fired_core = core;
        b.is_remote = rem; b.arm_nanos = arm; b.last = lst;
        return b;
    endfunction

    task automatic drain_time(logic [47:0] t);
        for (int i = 0; i < depth_used && t > 0; i++) begin
            if (delay_q[i] == 0) continue;
            if (t < delay_q[i]) begin
                delay_q[i] -= t;
                return;
            end
            t -= delay_q[i];
            delay_q[i] = 0;
        end
    endtask

    task automatic unlink(int pos);
        if (pos + 1 < depth_used) delay_q[pos+1] += delay_q[pos];
        for (int i = pos; i + 1 < depth_used; i++) begin
            delay_q[i] = delay_q[i+1]; id_q[i] = id_q[i+1]; core_q[i] = core_q[i+1];
        end
        depth_used--;
    endtask

    function automatic int locate(logic [5:0] id);
        for (int i = 0; i < depth_used; i++) if (id_q[i] == id) return i;
        return -1;
    endfunction

    task automatic predict_request(t_in_item rq);
        logic [2:0]  kind;
        logic [47:0] arm;
        logic [47:0] dly;
        int          pos;
        kind = KIND_ARM;
        arm  = '0;
        drain_time(rq.elapsed_nanos);
        case (rq.req_type)
            REQ_TICK: begin
                while (depth_used > 0 && delay_q[0] == 0) begin
                    expected_beats.push_back(mk_beat(KIND_FIRED, id_q[0], core_q[0],
                                             core_q[0] != owner, '0, 1'b0));
                    unlink(0);
                end
            end
            REQ_INSERT: begin
                if (locate(rq.event_id) >= 0) kind = KIND_DUP;
                else if (depth_used >= QUEUE_DEPTH) kind = KIND_FULL;
                else begin
                    pos = 0;
                    dly = rq.delay_nanos;
                    while (pos < depth_used && delay_q[pos] <= dly) begin
                        dly -= delay_q[pos];
                        pos++;
                    end
                    if (pos < depth_used) delay_q[pos] -= dly;
                    for (int i = depth_used; i > pos; i--) begin
                        delay_q[i] = delay_q[i-1]; id_q[i] = id_q[i-1];
                        core_q[i] = core_q[i-1];
                    end
                    delay_q[pos] = dly;
                    id_q[pos] = rq.event_id;
                    core_q[pos] = rq.any_core ? owner : rq.target_core;
                    depth_used++;
                end
            end
            REQ_REMOVE: begin
                pos = locate(rq.event_id);
                if (pos < 0) kind = KIND_NOTFOUND;
                else unlink(pos);
            end
            default: ;
        endcase
        if (depth_used > 0) arm = (delay_q[0] < max_arm) ? delay_q[0] : max_arm;
        else if (kind == KIND_ARM) kind = KIND_EMPTY;
        expected_beats.push_back(mk_beat(kind, '0, '0, 1'b0, arm, 1'b1));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            depth_used <= 0;
            max_arm <= '1;
            owner <= '0;
            o_errors <= 0;
            o_fired_seen <= 0;
            o_status_seen <= 0;
            expected_beats.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_TIMER_MAX) max_arm = i_cfg_data;
                else if (i_cfg_index == CFG_OWN_CORE) owner = i_cfg_data[7:0];
            end
            if (i_in_valid && !i_in_stall) predict_request(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                if (expected_beats.size() == 0) begin
                    $error("unexpected result beat kind=%0d", i_out_data.kind);
                    o_errors <= o_errors + 1;
                end else begin
                    t_out_item e;
                    int bad;
                    e = expected_beats.pop_front();
                    bad = 0;
                    if (e.kind != i_out_data.kind) begin
                        $error("kind exp %0d got %0d", e.kind, i_out_data.kind); bad++;
                    end
                    if (e.fired_id != i_out_data.fired_id) begin
                        $error("fired_id exp %0d got %0d", e.fired_id,
                               i_out_data.fired_id); bad++;
                    end
                    if (e.fired_core != i_out_data.fired_core) begin
                        $error("fired_core exp %0d got %0d", e.fired_core,
                               i_out_data.fired_core); bad++;
                    end
                    if (e.is_remote != i_out_data.is_remote) begin
                        $error("is_remote exp %0d got %0d", e.is_remote,
                               i_out_data.is_remote); bad++;
                    end
                    if (e.arm_nanos != i_out_data.arm_nanos) begin
                        $error("arm_nanos exp %0d got %0d", e.arm_nanos,
                               i_out_data.arm_nanos); bad++;
                    end
                    if (e.last != i_out_data.last) begin
                        $error("last exp %0d got %0d", e.last, i_out_data.last); bad++;
                    end
                    o_errors <= o_errors + bad;
                    if (e.last) o_status_seen <= o_status_seen + 1;
                    else o_fired_seen <= o_fired_seen + 1;
                end
            end
        end
    end

endmodule

// File: sim/delta_timer_event_queue_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_timer_event_queue_core_test
// Drives tick, insert, remove and unused-code requests with random elapsed
// times, idles and stalls both channels, reprograms the timer limit and owner
// core between phases, and takes the verdict from the scoreboard.
// ----------------------------------------------------------------------------
module delta_timer_event_queue_core_test;
    import dteq_pkg::*;

    localparam int DEPTH     = DEF_QUEUE_DEPTH;
    localparam int MAX_CYCLE = 1000000;
    localparam int DRAIN_GAP = 200; // settle margin after the last result beat

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in_item    in_data;
    logic        out_valid;
    logic        out_stall;
    t_out_item   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [47:0] cfg_data;
    int          errors;
    int          pending;
    int          fired_seen;
    int          status_seen;
    int          cycle;
    int          sent;

    // stall control: calm stretch disables random gaps, hold forces stall
    bit          calm;
    int          hold_cycles;

    delta_timer_event_queue_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    dteq_scoreboard #(.QUEUE_DEPTH(DEPTH)) checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_fired_seen  (fired_seen),
        .o_status_seen (status_seen)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("timeout after %0d cycles", cycle);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: random stall unless calm, forced stall during a hold
    always @(negedge clk) begin
        if (!rst_n) out_stall <= 1'b0;
        else if (hold_cycles > 0) begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else out_stall <= calm ? 1'b0 : ($urandom_range(99) < 38);
    end

    // one request beat; random idle gap first
    task automatic send_req(logic [1:0] rt, logic [47:0] el, logic [5:0] id,
                            logic [7:0] core, logic anyc, logic [47:0] dly);
        while (!calm && $urandom_range(99) < 38) @(negedge clk);
        in_data.req_type = rt;
        in_data.elapsed_nanos = el;
        in_data.event_id = id;
        in_data.target_core = core;
        in_data.any_core = anyc;
        in_data.delay_nanos = dly;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        in_valid = 1'b0;
        sent++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [47:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // wait for all predicted beats, then let the sequencer settle
    task automatic quiesce();
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_GAP) @(negedge clk);
    endtask

    // mostly small elapsed times so events survive, sometimes huge
    function automatic logic [47:0] rand_time(int span);
        int r;
        r = $urandom_range(99);
        if (r < 10) return '0;
        if (r < 15) return 48'({$urandom, $urandom});
        return 48'($urandom_range(span));
    endfunction

    task automatic random_phase(int count, int id_span);
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 45)
                send_req(REQ_INSERT, rand_time(60), 6'($urandom_range(id_span)),
                         8'($urandom), 1'($urandom_range(1)), rand_time(400));
            else if (r < 70)
                send_req(REQ_TICK, rand_time(150), 6'($urandom), 8'($urandom),
                         1'($urandom_range(1)), 48'({$urandom, $urandom}));
            else if (r < 92)
                send_req(REQ_REMOVE, rand_time(60), 6'($urandom_range(id_span)),
                         8'($urandom), 1'($urandom_range(1)),
                         48'({$urandom, $urandom}));
            else
                send_req(2'd3, rand_time(100), 6'($urandom), 8'($urandom),
                         1'($urandom_range(1)), 48'({$urandom, $urandom}));
        end
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_TIMER_MAX;
        cfg_data = '0;
        out_stall = 1'b0;
        calm = 1'b1;
        hold_cycles = 0;
        cycle = 0;
        sent = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty-queue cases, extremes, FIFO on equal delays
        send_req(REQ_TICK, '1, 6'd0, 8'd0, 1'b0, '0);
        send_req(REQ_REMOVE, '0, 6'd63, 8'd0, 1'b0, '0);
        send_req(2'd3, 48'd5, 6'd1, 8'd1, 1'b1, '1);
        send_req(REQ_INSERT, '0, 6'd63, 8'hFF, 1'b0, '1);
        send_req(REQ_INSERT, '0, 6'd63, 8'd3, 1'b0, 48'd5);      // duplicate
        send_req(REQ_INSERT, '0, 6'd1, 8'd0, 1'b1, 48'd100);
        send_req(REQ_INSERT, '0, 6'd2, 8'd7, 1'b0, 48'd100);      // same delay
        send_req(REQ_INSERT, '0, 6'd3, 8'd9, 1'b0, '0);           // zero delay
        send_req(REQ_INSERT, 48'd10, 6'd4, 8'd1, 1'b0, 48'd50);
        send_req(REQ_REMOVE, '0, 6'd4, 8'd0, 1'b0, '0);           // middle
        send_req(REQ_TICK, 48'd100, 6'd0, 8'd0, 1'b0, '0);
        send_req(REQ_REMOVE, '0, 6'd63, 8'd0, 1'b0, '0);          // last one
        // fill to full
        for (int i = 0; i < DEPTH; i++)
            send_req(REQ_INSERT, '0, 6'(i + 8), 8'(i), i[0], 48'(i * 3 + 1));
        send_req(REQ_INSERT, '0, 6'd40, 8'd0, 1'b0, 48'd2);       // full
        send_req(REQ_TICK, '1, 6'd0, 8'd0, 1'b0, '0);             // pops all
        quiesce();

        // small timer max, remote owner
        write_reg(CFG_TIMER_MAX, 48'd1);
        write_reg(CFG_OWN_CORE, 48'd5);
        calm = 1'b0;
        random_phase(70, 15);
        // pressure: receiver holds off while the sender keeps offering
        @(negedge clk);
        hold_cycles = 300;
        random_phase(20, 15);
        // sender pauses until everything is back
        quiesce();

        write_reg(CFG_TIMER_MAX, 48'd150);
        write_reg(CFG_OWN_CORE, 48'hFF);
        random_phase(70, 31);
        calm = 1'b1;
        random_phase(40, 31);
        calm = 1'b0;
        quiesce();

        write_reg(CFG_TIMER_MAX, '1);
        write_reg(CFG_OWN_CORE, 48'd0);
        random_phase(50, 63);

        quiesce();
        $display("covered %0d requests, %0d fired and %0d status beats checked",
                 sent, fired_seen, status_seen);
        $display("config changed over timer max 1, 150 and full range");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
